// ===== rtl/core/msev_pkg.sv =====
// Shared constants, codes and types of the perceptron scorer.
`default_nettype none
package msev_pkg;
  localparam int FEATURES     = 781;
  localparam int HIDDEN_ONE   = 16;
  localparam int HIDDEN_TWO   = 8;
  localparam int L1_BIAS_BASE = HIDDEN_ONE * FEATURES;
  localparam int L2_W_BASE    = L1_BIAS_BASE + HIDDEN_ONE;
  localparam int L2_BIAS_BASE = L2_W_BASE + HIDDEN_TWO * HIDDEN_ONE;
  localparam int L3_W_BASE    = L2_BIAS_BASE + HIDDEN_TWO;
  localparam int L3_BIAS_ADDR = L3_W_BASE + HIDDEN_TWO;
  localparam int STORE_SIZE   = L3_BIAS_ADDR + 1;

  localparam int WADDR_W = 14;
  localparam int FEAT_W  = 10;
  localparam int H1_W    = 4;
  localparam int K_W     = 5;

  localparam logic REG_SCALE  = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_EVAL  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_MARK = 2'd0,
    PH_L1   = 2'd1,
    PH_L2   = 2'd2,
    PH_L3   = 2'd3
  } phase_t;

  // Travels with each memory request down the datapath pipeline.
  typedef struct packed {
    logic             valid;
    phase_t           phase;
    logic [H1_W-1:0]  j;
    logic [K_W-1:0]   k;
    logic             last;
  } tag_t;
endpackage
`default_nettype wire

// ===== rtl/core/msev_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module msev_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/mlp_screlu_evaluator_unit.sv =====
// Top level of the SCReLU perceptron scorer: sequencer, memories and datapath.
// A feature mark of a feature already seen ends at the seen-map check; a new one then adds its weight column.
// An evaluation issues 16 + 136 + 9 weight reads, one per cycle on the weight
// memory read port, then drains the datapath pipeline before the score.
// After each evaluation and after reset a clearing pass clears the seen-map
// and the hidden sums; no request is taken then. Reset is synchronous.
`default_nettype none
module mlp_screlu_evaluator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // weight_address, weight_value, feature_index
  input  wire logic [1:0]  in_tuser,  // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // score, saturated
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_MARK_CHK  = 9'b000000100,
    S_MARK      = 9'b000001000,
    S_EVAL_WAIT = 9'b000010000,
    S_L1        = 9'b000100000,
    S_L2        = 9'b001000000,
    S_L3        = 9'b010000000,
    S_DRAIN     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [msev_pkg::FEAT_W-1:0]  feat_r, feat_nxt, clr_r, clr_nxt;
  logic [msev_pkg::WADDR_W-1:0] maddr_r, maddr_nxt;
  logic [msev_pkg::H1_W-1:0]    cnt_r, cnt_nxt;
  logic [msev_pkg::K_W-1:0]     k_r, k_nxt;
  msev_pkg::tag_t tag0, t1_r, t2_r, t3_r;

  logic [15:0] scale_r, offset_r;

  logic                         in_accept;
  msev_pkg::cmd_t               cmd;
  logic [msev_pkg::WADDR_W-1:0] in_addr;
  logic [15:0]                  in_value;
  logic [msev_pkg::FEAT_W-1:0]  in_feat;

  logic                         w_we;
  logic [msev_pkg::WADDR_W-1:0] w_raddr;
  logic [15:0]                  w_rdata;
  logic                         s_we, s_wdata, s_rdata;
  logic [msev_pkg::FEAT_W-1:0]  s_waddr;
  logic                         h_we;
  logic [msev_pkg::H1_W-1:0]    h_waddr, h_raddr;
  logic [31:0]                  h_wdata, h_rdata;

  logic [12:0] a1_r [msev_pkg::HIDDEN_ONE];
  logic [12:0] a2_r [msev_pkg::HIDDEN_TWO];
  logic signed [32:0] l1z_r;
  logic signed [29:0] prod_r;
  logic signed [33:0] acc_r, accsum, z3_r;
  logic signed [50:0] sprod_r;
  logic               fin4_r;
  logic signed [51:0] num;
  logic signed [27:0] q;
  logic               out_valid_r;
  logic [23:0]        out_data_r;
  logic [12:0]        a_sel, act1, act2;
  logic [23:0]        sq1;
  logic [47:0]        sq2;

  assign cmd       = msev_pkg::cmd_t'(in_tuser);
  assign in_addr   = in_tdata[13:0];
  assign in_value  = in_tdata[29:14];
  assign in_feat   = in_tdata[39:30];
  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid & in_tready;
  assign w_we      = in_accept && (cmd == msev_pkg::CMD_WRITE) &&
                     (in_addr < msev_pkg::WADDR_W'(msev_pkg::STORE_SIZE));

  msev_ram #(.WIDTH(16), .DEPTH(msev_pkg::STORE_SIZE)) u_weights (
    .clk(clk), .we(w_we), .waddr(in_addr), .wdata(in_value),
    .raddr(w_raddr), .rdata(w_rdata)
  );
  msev_ram #(.WIDTH(1), .DEPTH(msev_pkg::FEATURES)) u_seen (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(in_feat), .rdata(s_rdata)
  );
  msev_ram #(.WIDTH(32), .DEPTH(msev_pkg::HIDDEN_ONE)) u_hidden (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  // Sequencer: in S_MARK, S_L1, S_L2 and S_L3 issues one memory request per cycle with its tag.
  always_comb begin
    state_nxt = state_r;
    feat_nxt  = feat_r;
    clr_nxt   = clr_r;
    maddr_nxt = maddr_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    tag0      = '0;
    w_raddr   = '0;
    h_raddr   = cnt_r;
    s_we      = 1'b0;
    s_waddr   = feat_r;
    s_wdata   = 1'b0;
    case (state_r)
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == msev_pkg::FEAT_W'(msev_pkg::FEATURES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (cmd)
            msev_pkg::CMD_MARK: begin
              if (in_feat < msev_pkg::FEAT_W'(msev_pkg::FEATURES)) begin
                feat_nxt  = in_feat;
                state_nxt = S_MARK_CHK;
              end
            end
            msev_pkg::CMD_EVAL: state_nxt = S_EVAL_WAIT;
            default: ;
          endcase
        end
      end
      S_MARK_CHK: begin
        if (s_rdata) begin
          state_nxt = S_IDLE;
        end else begin
          s_we      = 1'b1;
          s_wdata   = 1'b1;
          cnt_nxt   = '0;
          maddr_nxt = msev_pkg::WADDR_W'(feat_r);
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        w_raddr   = maddr_r;
        tag0      = '{valid: 1'b1, phase: msev_pkg::PH_MARK, j: cnt_r, k: '0, last: 1'b0};
        maddr_nxt = maddr_r + msev_pkg::WADDR_W'(msev_pkg::FEATURES);
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == msev_pkg::H1_W'(msev_pkg::HIDDEN_ONE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_EVAL_WAIT: begin
        cnt_nxt = '0;
        if (!out_valid_r) begin
          state_nxt = S_L1;
        end
      end
      S_L1: begin
        w_raddr = msev_pkg::WADDR_W'(msev_pkg::L1_BIAS_BASE) + msev_pkg::WADDR_W'(cnt_r);
        tag0    = '{valid: 1'b1, phase: msev_pkg::PH_L1, j: cnt_r, k: '0, last: 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        k_nxt   = '0;
        if (cnt_r == msev_pkg::H1_W'(msev_pkg::HIDDEN_ONE - 1)) begin
          state_nxt = S_L2;
        end
      end
      S_L2: begin
        // Sixteen weights of neuron j, then its bias.
        if (k_r == msev_pkg::K_W'(msev_pkg::HIDDEN_ONE)) begin
          w_raddr = msev_pkg::WADDR_W'(msev_pkg::L2_BIAS_BASE) + msev_pkg::WADDR_W'(cnt_r);
        end else begin
          w_raddr = msev_pkg::WADDR_W'(msev_pkg::L2_W_BASE) +
                    msev_pkg::WADDR_W'({cnt_r, k_r[3:0]});
        end
        tag0 = '{valid: 1'b1, phase: msev_pkg::PH_L2, j: cnt_r, k: k_r,
                 last: (k_r == msev_pkg::K_W'(msev_pkg::HIDDEN_ONE))};
        k_nxt = k_r + 1'b1;
        if (k_r == msev_pkg::K_W'(msev_pkg::HIDDEN_ONE)) begin
          k_nxt   = '0;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == msev_pkg::H1_W'(msev_pkg::HIDDEN_TWO - 1)) begin
            state_nxt = S_L3;
          end
        end
      end
      S_L3: begin
        if (k_r == msev_pkg::K_W'(msev_pkg::HIDDEN_TWO)) begin
          w_raddr = msev_pkg::WADDR_W'(msev_pkg::L3_BIAS_ADDR);
        end else begin
          w_raddr = msev_pkg::WADDR_W'(msev_pkg::L3_W_BASE) + msev_pkg::WADDR_W'(k_r);
        end
        tag0 = '{valid: 1'b1, phase: msev_pkg::PH_L3, j: '0, k: k_r,
                 last: (k_r == msev_pkg::K_W'(msev_pkg::HIDDEN_TWO))};
        k_nxt = k_r + 1'b1;
        if (k_r == msev_pkg::K_W'(msev_pkg::HIDDEN_TWO)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        clr_nxt = '0;
        if (fin4_r) begin
          state_nxt = S_CLEAR;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Hidden sums: column add during a mark, zeroing during the clearing pass.
  always_comb begin
    h_we    = 1'b0;
    h_waddr = t1_r.j;
    h_wdata = h_rdata + {{16{w_rdata[15]}}, w_rdata};
    if (t1_r.valid && t1_r.phase == msev_pkg::PH_MARK) begin
      h_we = 1'b1;
    end else if (state_r == S_CLEAR &&
                 clr_r < msev_pkg::FEAT_W'(msev_pkg::HIDDEN_ONE)) begin
      h_we    = 1'b1;
      h_waddr = clr_r[msev_pkg::H1_W-1:0];
      h_wdata = '0;
    end
  end

  always_comb begin
    if (t1_r.phase == msev_pkg::PH_L2) begin
      a_sel = a1_r[t1_r.k[3:0]];
    end else begin
      a_sel = a2_r[t1_r.k[2:0]];
    end
    accsum = ((t2_r.k == '0) ? 34'sd0 : acc_r) + 34'(prod_r);
    sq1    = l1z_r[11:0] * l1z_r[11:0];
    if (l1z_r <= 33'sd0) begin
      act1 = '0;
    end else if (l1z_r >= 33'sd4096) begin
      act1 = 13'd4096;
    end else begin
      act1 = {1'b0, sq1[23:12]};
    end
    sq2 = z3_r[23:0] * z3_r[23:0];
    if (z3_r <= 34'sd0) begin
      act2 = '0;
    end else if (z3_r >= 34'sd16777216) begin
      act2 = 13'd4096;
    end else begin
      act2 = {1'b0, sq2[47:36]};
    end
    num = 52'(sprod_r) - $signed({12'd0, offset_r, 24'd0});
    // Divide by 2^24 truncating toward zero.
    if (num < 0) begin
      q = 28'((num + 52'sd16777215) >>> 24);
    end else begin
      q = 28'(num >>> 24);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      k_r         <= '0;
      feat_r      <= '0;
      maddr_r     <= '0;
      t1_r        <= '0;
      t2_r        <= '0;
      t3_r        <= '0;
      fin4_r      <= 1'b0;
      out_valid_r <= 1'b0;
      scale_r     <= 16'd40000;
      offset_r    <= 16'd20000;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      feat_r  <= feat_nxt;
      maddr_r <= maddr_nxt;
      t1_r    <= tag0;
      t2_r    <= t1_r;
      t3_r    <= (t2_r.valid && t2_r.last) ? t2_r : '0;
      fin4_r <= t3_r.valid && t3_r.phase == msev_pkg::PH_L3;
      if (fin4_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          msev_pkg::REG_SCALE:  scale_r  <= cfg_wdata;
          msev_pkg::REG_OFFSET: offset_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    l1z_r <= {h_rdata[31], h_rdata} + {{17{w_rdata[15]}}, w_rdata};
    if (t1_r.last) begin
      prod_r <= 30'($signed(w_rdata)) <<< 12;
    end else begin
      prod_r <= $signed({1'b0, a_sel}) * $signed(w_rdata);
    end
    if (t2_r.valid && t2_r.phase == msev_pkg::PH_L1) begin
      a1_r[t2_r.j] <= act1;
    end
    if (t2_r.valid && (t2_r.phase == msev_pkg::PH_L2 || t2_r.phase == msev_pkg::PH_L3)) begin
      acc_r <= accsum;
      z3_r  <= accsum;
    end
    if (t3_r.valid && t3_r.phase == msev_pkg::PH_L2) begin
      a2_r[t3_r.j[2:0]] <= act2;
    end
    sprod_r <= z3_r * $signed({1'b0, scale_r});
    if (fin4_r) begin
      if (q > 28'sd32767) begin
        out_data_r <= {7'd0, 1'b1, 16'h7FFF};
      end else if (q < -28'sd32768) begin
        out_data_r <= {7'd0, 1'b1, 16'h8000};
      end else begin
        out_data_r <= {7'd0, 1'b0, q[15:0]};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
endmodule
`default_nettype wire

// ===== rtl/core/msev_checker.sv =====
// Port-level checks of the scorer, bound to the top level.
`default_nettype none
module msev_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  // After reset the clearing pass keeps the input closed.
  a_reset_closed: assert property (@(posedge clk) !rst_n |=> !in_tready && !out_tvalid)
    else $error("input open or result shown right after reset");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15:0] == 16'h7FFF || out_tdata[15:0] == 16'h8000)
    else $error("saturated score not at a range limit");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // A new result never appears while the input is open in the same cycle.
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready)
    else $error("result produced while idle");
endmodule

bind mlp_screlu_evaluator_unit msev_checker u_msev_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// ===== sim/mlp_screlu_evaluator_unit_test.sv =====
// Self-checking testbench of the SCReLU perceptron scorer with a scoreboard class.
`timescale 1ns / 1ps
`default_nettype none
module mlp_screlu_evaluator_unit_test;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE      = 1000;
  localparam int POOL        = 24;

  class score_board;
    logic [15:0] wstore [msev_pkg::STORE_SIZE];
    logic [31:0] hsum [msev_pkg::HIDDEN_ONE];
    bit          seen [msev_pkg::FEATURES];
    logic [15:0] scale;
    logic [15:0] offset;
    logic [16:0] score_q [$];
    int          errors;

    function new();
      foreach (hsum[j]) hsum[j] = '0;
      foreach (seen[k]) seen[k] = 0;
      scale  = 16'd40000;
      offset = 16'd20000;
      errors = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] v);
      if (idx == msev_pkg::REG_SCALE) scale = v;
      else offset = v;
    endfunction

    function longint wval(int a);
      return longint'($signed(wstore[a]));
    endfunction

    function void note_request(msev_pkg::cmd_t c, logic [13:0] a, logic [15:0] v,
                               logic [9:0] f);
      longint a1 [msev_pkg::HIDDEN_ONE];
      longint a2 [msev_pkg::HIDDEN_TWO];
      longint z, y, q;
      bit     sat;
      case (c)
        msev_pkg::CMD_WRITE: begin
          if (a < msev_pkg::STORE_SIZE) wstore[a] = v;
        end
        msev_pkg::CMD_MARK: begin
          if (f < msev_pkg::FEATURES && !seen[f]) begin
            seen[f] = 1;
            for (int j = 0; j < msev_pkg::HIDDEN_ONE; j++)
              hsum[j] = hsum[j] + 32'(wval(j * msev_pkg::FEATURES + f));
          end
        end
        msev_pkg::CMD_EVAL: begin
          for (int j = 0; j < msev_pkg::HIDDEN_ONE; j++) begin
            z = longint'($signed(hsum[j])) + wval(msev_pkg::L1_BIAS_BASE + j);
            a1[j] = (z <= 0) ? 0 : (z >= 4096) ? 4096 : (z * z) >>> 12;
          end
          for (int j = 0; j < msev_pkg::HIDDEN_TWO; j++) begin
            z = wval(msev_pkg::L2_BIAS_BASE + j) * 4096;
            for (int k = 0; k < msev_pkg::HIDDEN_ONE; k++)
              z += a1[k] * wval(msev_pkg::L2_W_BASE + j * msev_pkg::HIDDEN_ONE + k);
            a2[j] = (z <= 0) ? 0 : (z >= 64'sd16777216) ? 4096 : (z * z) >>> 36;
          end
          y = wval(msev_pkg::L3_BIAS_ADDR) * 4096;
          for (int k = 0; k < msev_pkg::HIDDEN_TWO; k++)
            y += a2[k] * wval(msev_pkg::L3_W_BASE + k);
          // Signed division truncates toward zero, as the score requires.
          q = (y * longint'(scale) - longint'(offset) * 64'sd16777216) / 64'sd16777216;
          sat = 0;
          if (q > 32767) begin
            q = 32767;
            sat = 1;
          end else if (q < -32768) begin
            q = -32768;
            sat = 1;
          end
          score_q.push_back({sat, q[15:0]});
          foreach (hsum[j]) hsum[j] = '0;
          foreach (seen[k]) seen[k] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_score(logic [15:0] s, logic sat);
      logic [16:0] e;
      if (score_q.size() == 0) begin
        $error("score %0d arrived with nothing expected", $signed(s));
        errors++;
        return;
      end
      e = score_q.pop_front();
      if (s !== e[15:0]) begin
        $error("score: expected %0d, actual %0d", $signed(e[15:0]), $signed(s));
        errors++;
      end
      if (sat !== e[16]) begin
        $error("saturated: expected %0b, actual %0b", e[16], sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // weight_address, weight_value, feature_index
  logic [1:0]  in_tuser = '0;  // command
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;      // score, saturated
  logic        cfg_we = 0;
  logic        cfg_index = 0;
  logic [15:0] cfg_wdata = '0;

  score_board sb = new();
  int  stall_cycles = 0;
  bit  quiet = 0;
  int  sent = 0;

  mlp_screlu_evaluator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.set_reg(cfg_index, cfg_wdata);
      if (in_tvalid && in_tready)
        sb.note_request(msev_pkg::cmd_t'(in_tuser), in_tdata[13:0], in_tdata[29:14],
                        in_tdata[39:30]);
      if (out_tvalid && out_tready) sb.check_score(out_tdata[15:0], out_tdata[16]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The result side stalls on its own schedule.
  initial begin
    @(posedge clk);
    forever begin
      out_tready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (pick_gap() > 0) begin
        out_tready <= 0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  task automatic send(msev_pkg::cmd_t c, int a, int v, int f);
    int gap;
    in_tvalid <= 1;
    in_tuser  <= c;
    in_tdata  <= {f[9:0], v[15:0], a[13:0]};
    do @(posedge clk); while (!in_tready);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 1200) - 600;
    if (r < 90) return $urandom_range(0, 8192) - 4096;
    return $urandom_range(0, 65535);
  endfunction

  // Marks use a small pool of features at both ends of the index range.
  function automatic int pool_feature(int i);
    if (i < POOL / 2) return i;
    return msev_pkg::FEATURES - POOL + i;
  endfunction

  // Mostly pool features, sometimes repeats or indices past the top.
  function automatic int rand_feature();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return pool_feature($urandom_range(0, POOL - 1));
    if (r < 95) return $urandom_range(0, POOL / 2 - 1);
    return $urandom_range(msev_pkg::FEATURES, 1023);
  endfunction

  task automatic write_reg(logic idx, int v);
    cfg_we    <= 1;
    cfg_index <= idx;
    cfg_wdata <= v[15:0];
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.score_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_run(int n);
    int r, goal;
    goal = sent + n;
    while (sent < goal) begin
      repeat ($urandom_range(0, 20)) begin
        r = $urandom_range(0, 99);
        if (r < 85) send(msev_pkg::CMD_MARK, $urandom, $urandom, rand_feature());
        else if (r < 93) send(msev_pkg::CMD_WRITE, $urandom_range(0, msev_pkg::STORE_SIZE - 1),
                              rand_weight(), $urandom);
        else if (r < 96) send(msev_pkg::CMD_WRITE, $urandom_range(msev_pkg::STORE_SIZE, 16383),
                              $urandom, $urandom);
        else send(msev_pkg::CMD_NONE, $urandom, $urandom, $urandom);
      end
      send(msev_pkg::CMD_EVAL, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // The pool columns and all later layers hold a value before anything reads them.
    quiet = 1;
    for (int i = 0; i < POOL; i++)
      for (int j = 0; j < msev_pkg::HIDDEN_ONE; j++)
        send(msev_pkg::CMD_WRITE, j * msev_pkg::FEATURES + pool_feature(i), rand_weight(),
             $urandom);
    for (int a = msev_pkg::L1_BIAS_BASE; a < msev_pkg::STORE_SIZE; a++)
      send(msev_pkg::CMD_WRITE, a, rand_weight(), $urandom);
    quiet = 0;

    // Directed requests at reset configuration.
    send(msev_pkg::CMD_EVAL, 0, 0, 0);
    send(msev_pkg::CMD_MARK, 16383, 65535, 0);
    send(msev_pkg::CMD_MARK, 0, 0, msev_pkg::FEATURES - 1);
    send(msev_pkg::CMD_MARK, 0, 0, msev_pkg::FEATURES - 1);
    send(msev_pkg::CMD_MARK, 0, 0, msev_pkg::FEATURES);
    send(msev_pkg::CMD_MARK, 0, 0, 1023);
    send(msev_pkg::CMD_NONE, 16383, 65535, 1023);
    send(msev_pkg::CMD_WRITE, 16383, 16'h7fff, 0);
    send(msev_pkg::CMD_WRITE, msev_pkg::STORE_SIZE, 16'h8000, 0);
    // A weight written during marking only affects columns added later.
    send(msev_pkg::CMD_WRITE, 5, 16'h7fff, 0);
    send(msev_pkg::CMD_WRITE, msev_pkg::FEATURES + 5, 16'h8000, 0);
    send(msev_pkg::CMD_MARK, 0, 0, 5);
    send(msev_pkg::CMD_WRITE, 5, 0, 0);
    send(msev_pkg::CMD_EVAL, 0, 0, 0);
    send(msev_pkg::CMD_WRITE, msev_pkg::L3_BIAS_ADDR, 16'h7fff, 0);
    send(msev_pkg::CMD_EVAL, 0, 0, 0);
    send(msev_pkg::CMD_WRITE, msev_pkg::L3_BIAS_ADDR, 16'h8000, 0);
    send(msev_pkg::CMD_EVAL, 0, 0, 0);
    send(msev_pkg::CMD_WRITE, msev_pkg::L3_BIAS_ADDR, 0, 0);
    random_run(60);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(msev_pkg::REG_SCALE, 0);
          write_reg(msev_pkg::REG_OFFSET, 0);
        end
        1: begin
          write_reg(msev_pkg::REG_SCALE, 65535);
          write_reg(msev_pkg::REG_OFFSET, 65535);
        end
        2: begin
          write_reg(msev_pkg::REG_SCALE, 65535);
          write_reg(msev_pkg::REG_OFFSET, 0);
        end
        3: begin
          write_reg(msev_pkg::REG_SCALE, 0);
          write_reg(msev_pkg::REG_OFFSET, 65535);
        end
        default: begin
          write_reg(msev_pkg::REG_SCALE, $urandom_range(0, 65535));
          write_reg(msev_pkg::REG_OFFSET, $urandom_range(0, 65535));
        end
      endcase
      quiet = (p == 2);
      send(msev_pkg::CMD_EVAL, 0, 0, 0);
      random_run(50);
      drain();
    end

    if (sb.errors == 0 && sb.score_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
